[src/dcct_pkg.sv]
// Shared types, constants and reciprocal divisors for the day count to civil time pipeline.
// No dependencies; imported by every module of the block.
package dcct_pkg;

	localparam int NUM_STAGES = 9;
	typedef logic [NUM_STAGES:1] stage_vec_t;

	// Field widths
	localparam int DAY_W    = 23;
	localparam int FRAC_W   = 32;
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DOM_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int MICROS_W = 26;

	typedef struct packed {
		logic signed [DAY_W-1:0] day_number;
		logic [FRAC_W-1:0]       day_fraction;
	} request_t;

	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DOM_W-1:0]    day_of_month;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [MICROS_W-1:0] micros_in_minute;
		logic                out_of_range;
	} result_t;

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [MICROS_W-1:0] micros;
	} tod_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DOM_W-1:0]   day_of_month;
		logic               out_of_range;
	} date_t;

	// Fraction to microseconds: 86400e6 = 10546875 * 2^13
	localparam logic [23:0] DAY_US_ODD   = 24'd10546875;
	localparam int          DAY_US_SHIFT = 13;
	localparam int          US_W         = 37;
	localparam logic [US_W-1:0] US_PER_DAY = 37'd86400000000;
	localparam logic [MICROS_W-1:0] US_PER_MINUTE = 26'd60000000;

	// Exact division by constant: q = (x * R) >> K, R = ceil(2^K / D), K = N + clog2(D)
	// Total minutes: us / 60e6 = (us >> 8) / 234375
	localparam int MIN_PRE_SHIFT = 8;
	localparam int MIN_DIV       = 234375;
	localparam int MIN_N         = US_W - MIN_PRE_SHIFT;
	localparam int MIN_K         = MIN_N + $clog2(MIN_DIV);
	localparam longint unsigned MIN_RECIP =
		((64'd1 << MIN_K) + 64'(MIN_DIV) - 64'd1) / 64'(MIN_DIV);
	localparam int MIN_RW        = $clog2(MIN_RECIP + 64'd1);
	localparam int MINS_W        = 11;

	localparam int MINS_PER_HOUR = 60;
	localparam int HOUR_K        = MINS_W + $clog2(MINS_PER_HOUR);
	localparam longint unsigned HOUR_RECIP =
		((64'd1 << HOUR_K) + 64'(MINS_PER_HOUR) - 64'd1) / 64'(MINS_PER_HOUR);
	localparam int HOUR_RW       = $clog2(HOUR_RECIP + 64'd1);

	// Era split; the bias keeps the shifted day count non-negative for any input pattern
	localparam int DAYS_PER_ERA  = 146097;
	localparam int YEARS_PER_ERA = 400;
	localparam int ERA_BIAS      = 24;
	localparam int EPOCH_SHIFT   = 719468;
	localparam int ZO_W          = 24;
	localparam int ZO_OFFSET     = EPOCH_SHIFT + ERA_BIAS * DAYS_PER_ERA;
	localparam int ERA_K         = ZO_W + $clog2(DAYS_PER_ERA);
	localparam longint unsigned ERA_RECIP =
		((64'd1 << ERA_K) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA);
	localparam int ERA_RW        = $clog2(ERA_RECIP + 64'd1);
	localparam int ERA_W         = 6;

	// Day of era to year of era
	localparam int DOE_W     = 18;
	localparam int DOE_LAST  = 146096;
	localparam int Q4_DIV    = 1460;
	localparam int Q4_K      = DOE_W + $clog2(Q4_DIV);
	localparam longint unsigned Q4_RECIP =
		((64'd1 << Q4_K) + 64'(Q4_DIV) - 64'd1) / 64'(Q4_DIV);
	localparam int Q4_RW     = $clog2(Q4_RECIP + 64'd1);
	localparam int Q4_QW     = 7;
	localparam int CENT_DIV  = 36524;
	localparam int CENT_K    = DOE_W + $clog2(CENT_DIV);
	localparam longint unsigned CENT_RECIP =
		((64'd1 << CENT_K) + 64'(CENT_DIV) - 64'd1) / 64'(CENT_DIV);
	localparam int CENT_RW   = $clog2(CENT_RECIP + 64'd1);
	localparam int CENT_QW   = 3;
	localparam int YEAR_DAYS = 365;
	localparam int YOE_K     = DOE_W + $clog2(YEAR_DAYS);
	localparam longint unsigned YOE_RECIP =
		((64'd1 << YOE_K) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS);
	localparam int YOE_RW    = $clog2(YOE_RECIP + 64'd1);
	localparam int YOE_W     = 9;
	localparam int C100_DIV  = 100;
	localparam int C100_K    = YOE_W + $clog2(C100_DIV);
	localparam longint unsigned C100_RECIP =
		((64'd1 << C100_K) + 64'(C100_DIV) - 64'd1) / 64'(C100_DIV);
	localparam int C100_RW   = $clog2(C100_RECIP + 64'd1);
	localparam int C100_QW   = 2;

	// Day of year to March-based month
	localparam int DOY_W      = 9;
	localparam int MP_N       = 11;
	localparam int MP_DIV     = 153;
	localparam int MP_K       = MP_N + $clog2(MP_DIV);
	localparam longint unsigned MP_RECIP =
		((64'd1 << MP_K) + 64'(MP_DIV) - 64'd1) / 64'(MP_DIV);
	localparam int MP_RW      = $clog2(MP_RECIP + 64'd1);
	localparam int MP_W       = 4;
	localparam int MP_JANUARY = 10;

	localparam int YEAR_CALC_W = 16;
	localparam int YEAR_MAX    = 9999;
	localparam int YEAR_MIN    = 1;

	// First day of year-of-March index for each March-based month, (153*mp+2)/5
	function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
		logic [DOY_W-1:0] s;
		case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

[src/dcct_time_path.sv]
// Time-of-day datapath: fraction to rounded microseconds, day carry, hour/minute/micros.
// Depends on dcct_pkg; stage enables come from the top-level pipeline control.
module dcct_time_path
	import dcct_pkg::*;
#(
	parameter int FRACTION_BITS = 32
) (
	input  logic              clk,
	input  stage_vec_t        stage_en,
	input  logic [FRAC_W-1:0] day_fraction,
	output logic              day_carry,
	output tod_t              tod
);

	localparam int FRAC_IN_W = (FRACTION_BITS < FRAC_W) ? FRACTION_BITS : FRAC_W;
	localparam logic [FRAC_W-1:0] FRAC_MASK = FRAC_W'((64'd1 << FRAC_IN_W) - 64'd1);
	localparam int PROD_W   = FRAC_W + 24;
	localparam int SUM_W    = PROD_W + 1;
	localparam int US_SHIFT = FRACTION_BITS - DAY_US_SHIFT;
	localparam logic [SUM_W-1:0] US_ROUND = SUM_W'(1) << (US_SHIFT - 1);

	logic [PROD_W-1:0]   frac_prod_s1;
	logic [SUM_W-1:0]    us_sum;
	logic [SUM_W-1:0]    us_shifted;
	logic [US_W-1:0]     us_raw;
	logic [US_W-1:0]     us_s2;
	logic [MIN_N+MIN_RW-1:0] min_prod;
	logic [MINS_W-1:0]   mins_s3;
	logic [MICROS_W-1:0] us_lo_s3;
	logic [MINS_W+HOUR_RW-1:0] hour_prod;
	logic [MINS_W-1:0]   mins_s4;
	logic [HOUR_W-1:0]   hour_s4;
	logic [MICROS_W-1:0] us_lo_s4;
	logic [MICROS_W-1:0] usm_lo_s4;
	logic [MINS_W-1:0]   minute_full;
	tod_t                tod_s5, tod_s6, tod_s7, tod_s8, tod_s9;

	// Stage 1: scale by the odd part of 86400e6
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			frac_prod_s1 <= PROD_W'(day_fraction & FRAC_MASK) * PROD_W'(DAY_US_ODD);
		end
	end

	// Stage 2: round half up, fold a full day into the date
	assign us_sum     = SUM_W'(frac_prod_s1) + US_ROUND;
	assign us_shifted = us_sum >> US_SHIFT;
	assign us_raw     = us_shifted[US_W-1:0];
	assign day_carry  = (us_raw == US_PER_DAY);

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			us_s2 <= day_carry ? '0 : us_raw;
		end
	end

	// Stage 3: total minutes of the day
	assign min_prod = (MIN_N+MIN_RW)'(us_s2[US_W-1:MIN_PRE_SHIFT])
		* (MIN_N+MIN_RW)'(MIN_RECIP);

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			mins_s3  <= min_prod[MIN_K +: MINS_W];
			us_lo_s3 <= us_s2[MICROS_W-1:0];
		end
	end

	// Stage 4: hour and the minute start in microseconds (mod 2^26 is enough)
	assign hour_prod = (MINS_W+HOUR_RW)'(mins_s3) * (MINS_W+HOUR_RW)'(HOUR_RECIP);

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			hour_s4   <= hour_prod[HOUR_K +: HOUR_W];
			mins_s4   <= mins_s3;
			us_lo_s4  <= us_lo_s3;
			usm_lo_s4 <= MICROS_W'(mins_s3) * US_PER_MINUTE;
		end
	end

	// Stage 5: remainders
	assign minute_full = mins_s4 - MINS_W'(hour_s4) * MINS_W'(MINS_PER_HOUR);

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			tod_s5.hour   <= hour_s4;
			tod_s5.minute <= minute_full[MINUTE_W-1:0];
			tod_s5.micros <= us_lo_s4 - usm_lo_s4;
		end
	end

	// Stages 6..9: align with the date path
	always_ff @(posedge clk) begin
		if (stage_en[6]) tod_s6 <= tod_s5;
		if (stage_en[7]) tod_s7 <= tod_s6;
		if (stage_en[8]) tod_s8 <= tod_s7;
		if (stage_en[9]) tod_s9 <= tod_s8;
	end

	assign tod = tod_s9;

endmodule

[src/dcct_date_path.sv]
// Civil date datapath: day count plus carry to year, month, day of month, range flag.
// Depends on dcct_pkg; stage enables come from the top-level pipeline control.
module dcct_date_path
	import dcct_pkg::*;
(
	input  logic                    clk,
	input  stage_vec_t              stage_en,
	input  logic signed [DAY_W-1:0] day_number,
	input  logic                    day_carry,
	output date_t                   date
);

	localparam logic signed [YEAR_CALC_W-1:0] Y_MAX_S = YEAR_CALC_W'(YEAR_MAX);
	localparam logic signed [YEAR_CALC_W-1:0] Y_MIN_S = YEAR_CALC_W'(YEAR_MIN);

	logic signed [DAY_W-1:0] day_s1;
	logic [ZO_W-1:0]         zo_s2, zo_s3;
	logic [ZO_W+ERA_RW-1:0]  era_prod;
	logic [ERA_W-1:0]        era_s3, era_s4, era_s5, era_s6, era_s7;
	logic [DOE_W-1:0]        doe_s4, doe_s5, doe_s6;
	logic [DOE_W+Q4_RW-1:0]  q4_prod;
	logic [DOE_W+CENT_RW-1:0] cent_prod;
	logic [DOE_W-1:0]        t_s5;
	logic [DOE_W+YOE_RW-1:0] yoe_prod;
	logic [YOE_W-1:0]        yoe_s6, yoe_s7;
	logic [YOE_W+C100_RW-1:0] c100_prod;
	logic [DOE_W-1:0]        yday_sub;
	logic [DOE_W-1:0]        doy_full;
	logic [DOY_W-1:0]        doy_s7, doy_s8;
	logic [MP_N-1:0]         mp_num;
	logic [MP_N+MP_RW-1:0]   mp_prod;
	logic [MP_W-1:0]         mp_s8;
	logic signed [YEAR_CALC_W-1:0] ybase_s8;
	logic signed [YEAR_CALC_W-1:0] year_full;
	logic                    jan_feb;
	logic [MONTH_W-1:0]      month_c;
	logic [DOY_W-1:0]        dom_full;
	date_t                   date_s9;

	// Stage 1/2: biased day count, always non-negative
	always_ff @(posedge clk) begin
		if (stage_en[1]) day_s1 <= day_number;
		if (stage_en[2]) begin
			zo_s2 <= ZO_W'(day_s1) + ZO_W'(ZO_OFFSET) + ZO_W'(day_carry);
		end
	end

	// Stage 3: era index
	assign era_prod = (ZO_W+ERA_RW)'(zo_s2) * (ZO_W+ERA_RW)'(ERA_RECIP);

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			era_s3 <= era_prod[ERA_K +: ERA_W];
			zo_s3  <= zo_s2;
		end
	end

	// Stage 4: day of era
	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			doe_s4 <= DOE_W'(zo_s3 - ZO_W'(era_s3) * ZO_W'(DAYS_PER_ERA));
			era_s4 <= era_s3;
		end
	end

	// Stage 5: leap-day corrected day of era
	assign q4_prod   = (DOE_W+Q4_RW)'(doe_s4) * (DOE_W+Q4_RW)'(Q4_RECIP);
	assign cent_prod = (DOE_W+CENT_RW)'(doe_s4) * (DOE_W+CENT_RW)'(CENT_RECIP);

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			t_s5   <= doe_s4 - DOE_W'(q4_prod[Q4_K +: Q4_QW])
				+ DOE_W'(cent_prod[CENT_K +: CENT_QW])
				- DOE_W'(doe_s4 == DOE_W'(DOE_LAST));
			doe_s5 <= doe_s4;
			era_s5 <= era_s4;
		end
	end

	// Stage 6: year of era
	assign yoe_prod = (DOE_W+YOE_RW)'(t_s5) * (DOE_W+YOE_RW)'(YOE_RECIP);

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			yoe_s6 <= yoe_prod[YOE_K +: YOE_W];
			doe_s6 <= doe_s5;
			era_s6 <= era_s5;
		end
	end

	// Stage 7: day of year (March based)
	assign c100_prod = (YOE_W+C100_RW)'(yoe_s6) * (YOE_W+C100_RW)'(C100_RECIP);
	assign yday_sub  = DOE_W'(yoe_s6) * DOE_W'(YEAR_DAYS) + DOE_W'(yoe_s6 >> 2)
		- DOE_W'(c100_prod[C100_K +: C100_QW]);
	assign doy_full  = doe_s6 - yday_sub;

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			doy_s7 <= doy_full[DOY_W-1:0];
			yoe_s7 <= yoe_s6;
			era_s7 <= era_s6;
		end
	end

	// Stage 8: March-based month, year before the Jan/Feb adjust
	assign mp_num  = MP_N'(doy_s7) * MP_N'(5) + MP_N'(2);
	assign mp_prod = (MP_N+MP_RW)'(mp_num) * (MP_N+MP_RW)'(MP_RECIP);

	always_ff @(posedge clk) begin
		if (stage_en[8]) begin
			mp_s8    <= mp_prod[MP_K +: MP_W];
			doy_s8   <= doy_s7;
			ybase_s8 <= YEAR_CALC_W'(era_s7) * YEAR_CALC_W'(YEARS_PER_ERA)
				+ YEAR_CALC_W'(yoe_s7) - YEAR_CALC_W'(ERA_BIAS * YEARS_PER_ERA);
		end
	end

	// Stage 9: calendar fields and saturation (output register)
	assign jan_feb   = (mp_s8 >= MP_W'(MP_JANUARY));
	assign month_c   = jan_feb ? MONTH_W'(mp_s8 - MP_W'(MP_JANUARY) + MP_W'(1))
		: MONTH_W'(mp_s8 + MP_W'(3));
	assign dom_full  = doy_s8 - month_start(mp_s8) + DOY_W'(1);
	assign year_full = ybase_s8 + YEAR_CALC_W'(jan_feb);

	always_ff @(posedge clk) begin
		if (stage_en[9]) begin
			date_s9.month        <= month_c;
			date_s9.day_of_month <= dom_full[DOM_W-1:0];
			if (year_full > Y_MAX_S) begin
				date_s9.year         <= YEAR_W'(YEAR_MAX);
				date_s9.out_of_range <= 1'b1;
			end else if (year_full < Y_MIN_S) begin
				date_s9.year         <= YEAR_W'(YEAR_MIN);
				date_s9.out_of_range <= 1'b1;
			end else begin
				date_s9.year         <= year_full[YEAR_W-1:0];
				date_s9.out_of_range <= 1'b0;
			end
		end
	end

	assign date = date_s9;

endmodule

[src/day_count_to_civil_time.sv]
// A request accepted at a rising edge is loaded into stage 1 and leaves as a valid result
// from stage 9; nine register stages, stage 9 is the output register.
// Throughput: one request per cycle while results are taken; a stall freezes the occupied
// run back from stage 9; empty stages keep filling, so no request is dropped or repeated.
// Reset: arst_n clears only the per-stage valid bits; datapath registers are not reset.
// Depends on dcct_pkg, dcct_time_path, dcct_date_path.
module day_count_to_civil_time
	import dcct_pkg::*;
#(
	parameter int FRACTION_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  request_t item,
	output logic     result_valid,
	input  logic     result_ready,
	output result_t  result
);

	logic [NUM_STAGES:1] vld_q;
	stage_vec_t          stage_en;
	logic                day_carry;
	tod_t                tod;
	date_t               date;

	// Stall chain: a stage may load when it is empty or the stage after it moves.
	always_comb begin
		stage_en[NUM_STAGES] = !vld_q[NUM_STAGES] || result_ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k+1];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[1]) vld_q[1] <= item_valid;
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (stage_en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign item_ready   = stage_en[1];
	assign result_valid = vld_q[NUM_STAGES];

	// Time of day; also decides the rounding carry into the date at stage 2.
	dcct_time_path #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_time (
		.clk         (clk),
		.stage_en    (stage_en),
		.day_fraction(item.day_fraction),
		.day_carry   (day_carry),
		.tod         (tod)
	);

	// Proleptic Gregorian date from the carried day count.
	dcct_date_path u_date (
		.clk       (clk),
		.stage_en  (stage_en),
		.day_number(item.day_number),
		.day_carry (day_carry),
		.date      (date)
	);

	always_comb begin
		result.year             = date.year;
		result.month            = date.month;
		result.day_of_month     = date.day_of_month;
		result.hour             = tod.hour;
		result.minute           = tod.minute;
		result.micros_in_minute = tod.micros;
		result.out_of_range     = date.out_of_range;
	end

	// An accepted request always lands in stage 1.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> vld_q[1])
		else $error("accepted request missing from stage 1");

	// An empty first stage never blocks a request.
	a_ready_when_s1_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[1] |-> item_ready)
		else $error("ready low with stage 1 empty");

	// Saturation only ever lands on the range limits.
	a_oor_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.out_of_range)
		|-> (result.year == YEAR_W'(YEAR_MAX) || result.year == YEAR_W'(YEAR_MIN)))
		else $error("out_of_range without saturated year");

	// Calendar and clock fields stay inside their ranges.
	a_fields_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.month >= MONTH_W'(1) && result.month <= MONTH_W'(12)
		&& result.day_of_month >= DOM_W'(1) && result.day_of_month <= DOM_W'(31)
		&& result.hour <= HOUR_W'(23) && result.minute <= MINUTE_W'(59)
		&& result.micros_in_minute < US_PER_MINUTE))
		else $error("result field out of range");

endmodule

[tb/tb.sv]
// Self-checking testbench for day_count_to_civil_time: directed calendar and rounding
// cases, then random requests under four sender/receiver idling mixes.
// Depends on dcct_pkg (request_t, result_t, field widths) and the RTL top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dcct_pkg::*;

	// Fraction format under test; the predictor follows the same value.
	localparam int FRAC_BITS = 32;

	// Legal day range: 0001-01-01 .. 9999-12-31, counted from 1970-01-01.
	localparam longint FIRST_DAY = -719162;
	localparam longint LAST_DAY  = 2932896;

	localparam longint unsigned MICROS_IN_DAY    = 64'd86400000000;
	localparam longint unsigned MICROS_IN_HOUR   = 64'd3600000000;
	localparam longint unsigned MICROS_IN_MINUTE = 64'd60000000;
	// 86400e6 = 10546875 * 2^13, so the fraction product stays below 2^56.
	localparam longint unsigned DAY_MICROS_ODD   = 64'd10546875;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     item_valid   = 1'b0;
	logic     item_ready;
	request_t item         = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	result_t  result;

	// Idle rates in percent, changed per phase by the random test.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int mismatch_count = 0;

	// Expected civil times, oldest first, one per accepted request.
	result_t civil_time_queue[$];

	day_count_to_civil_time #(
		.FRACTION_BITS(FRAC_BITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #4 clk = ~clk;

	// Predicted conversion of one request. The fraction becomes whole microseconds,
	// rounded half up; a round-up to a full day rolls the date forward. The date
	// comes from the era / day-of-era decomposition with March as month zero, so
	// the leap day always lands at the end of the shifted year.
	function automatic result_t predict_civil_time(request_t req);
		longint unsigned frac;
		longint unsigned micros;
		longint          days;
		longint          z;
		longint          era;
		longint          doe;
		longint          yoe;
		longint          doy;
		longint          mp;
		longint          mo;
		longint          yr;
		longint          dom;
		result_t         r;
		frac = 64'(req.day_fraction);
		if (FRAC_BITS < 32)
			frac &= (64'd1 << FRAC_BITS) - 64'd1;
		micros = (frac * DAY_MICROS_ODD + (64'd1 << (FRAC_BITS - 14))) >> (FRAC_BITS - 13);
		days = longint'($signed(req.day_number));
		if (micros >= MICROS_IN_DAY) begin
			micros -= MICROS_IN_DAY;
			days += 1;
		end
		// Signed divisions truncate toward zero; the era floor is done by hand.
		z   = days + 719468;
		era = (z >= 0 ? z : z - 146096) / 146097;
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp  = (5 * doy + 2) / 153;
		mo  = (mp < 10) ? mp + 3 : mp - 9;
		dom = doy - (153 * mp + 2) / 5 + 1;
		yr  = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
		r.out_of_range = 1'b0;
		// Years outside 1..9999 saturate; month and day keep the calendar values.
		if (yr > 9999) begin
			yr = 9999;
			r.out_of_range = 1'b1;
		end else if (yr < 1) begin
			yr = 1;
			r.out_of_range = 1'b1;
		end
		r.year             = YEAR_W'(yr);
		r.month            = MONTH_W'(mo);
		r.day_of_month     = DOM_W'(dom);
		r.hour             = HOUR_W'(micros / MICROS_IN_HOUR);
		r.minute           = MINUTE_W'((micros % MICROS_IN_HOUR) / MICROS_IN_MINUTE);
		r.micros_in_minute = MICROS_W'(micros % MICROS_IN_MINUTE);
		return r;
	endfunction

	// Drive one request and hold it until the block takes it. Valid is only
	// lowered for an idle gap, so back-to-back requests keep it high.
	task automatic send_request(input request_t req);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= req;
		do
			@(posedge clk);
		while (!item_ready);
		civil_time_queue.insert(civil_time_queue.size(), predict_civil_time(req));
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk) begin
		result_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	// Every result taken is compared against the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (civil_time_queue.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
			end else begin
				want = civil_time_queue.pop_front();
				check_field("year", want.year, result.year);
				check_field("month", want.month, result.month);
				check_field("day_of_month", want.day_of_month, result.day_of_month);
				check_field("hour", want.hour, result.hour);
				check_field("minute", want.minute, result.minute);
				check_field("micros_in_minute", want.micros_in_minute,
					result.micros_in_minute);
				check_field("out_of_range", want.out_of_range, result.out_of_range);
			end
		end
	end

	// Epoch, the legal extremes, and leap-year handling across century rules.
	task automatic test_calendar_edges();
		request_t req;
		longint   days[7] = '{0, -1, FIRST_DAY, LAST_DAY, 11016, -25509, -25508};
		// 11016 is 2000-02-29; -25509 / -25508 straddle 1900, which has no leap day.
		foreach (days[i]) begin
			req.day_number   = DAY_W'(days[i]);
			req.day_fraction = (i % 2 == 0) ? 32'h0000_0000 : 32'h8000_0000;
			send_request(req);
		end
	endtask

	// Microsecond rounding: zero, one LSB, exact half (rounds up), just under half,
	// noon, a minute edge, and the largest fraction (just under midnight).
	task automatic test_time_rounding();
		request_t    req;
		logic [31:0] fracs[7];
		fracs = '{32'h0, 32'h1, 32'h0003_FFFF, 32'h0004_0000, 32'h8000_0000,
			32'((64'd1 << 32) / 1440), 32'hFFFF_FFFF};
		foreach (fracs[i]) begin
			req.day_number   = DAY_W'(i * 40000 - 100000);
			req.day_fraction = fracs[i];
			send_request(req);
		end
	endtask

	// Dates one day past either legal end, and the extremes of the 23-bit field.
	task automatic test_out_of_range();
		request_t req;
		longint   days[4] = '{FIRST_DAY - 1, LAST_DAY + 1, -4194304, 4194303};
		foreach (days[i]) begin
			req.day_number   = DAY_W'(days[i]);
			req.day_fraction = 32'hFFFF_FFFF;
			send_request(req);
		end
	endtask

	// Random requests: mostly legal dates, with extra weight on the range ends,
	// 400-year era edges and raw 23-bit patterns; fractions weighted toward minute
	// edges, exact half-microsecond points and the ends of the fraction range.
	task automatic test_random_traffic(input int count, input int send_pct, input int stall_pct);
		request_t        req;
		int unsigned     pick;
		longint          day;
		longint unsigned frac;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 65)
				day = longint'($urandom_range(LAST_DAY - FIRST_DAY)) + FIRST_DAY;
			else if (pick < 78)
				day = ((pick < 72) ? FIRST_DAY : LAST_DAY) + longint'($urandom_range(6)) - 3;
			else if (pick < 88)
				day = (longint'($urandom_range(28)) - 4) * 146097 - 719468
					+ longint'($urandom_range(4)) - 2;
			else
				day = longint'($signed(DAY_W'($urandom())));
			req.day_number = DAY_W'(day);

			pick = $urandom_range(99);
			if (pick < 60)
				frac = 64'($urandom());
			else if (pick < 75)
				frac = (64'($urandom_range(1440)) << 32) / 1440 + 64'($urandom_range(6)) - 3;
			else if (pick < 85)
				frac = 64'({$urandom() >> 19, 19'h4_0000}) + 64'($urandom_range(2)) - 1;
			else if (pick < 92)
				frac = 64'($urandom_range(15));
			else
				frac = 64'(32'hFFFF_FFFF - $urandom_range(15));
			req.day_fraction = 32'(frac);
			send_request(req);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_calendar_edges();
		test_time_rounding();
		test_out_of_range();
		test_random_traffic(345, 0, 0);
		test_random_traffic(345, 83, 0);
		test_random_traffic(345, 0, 83);
		test_random_traffic(345, 33, 33);

		// Drain: stop sending, let the receiver run free, then keep clocking to catch any
		// stray extra result.
		item_valid     <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (civil_time_queue.size() != 0)
			@(posedge clk);
		repeat (2 * NUM_STAGES + 4) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Hang guard: the slowest correct run is well under 200 us.
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
src/dcct_pkg.sv
src/dcct_time_path.sv
src/dcct_date_path.sv
src/day_count_to_civil_time.sv
tb/tb.sv
